>>> hw/rtl/assert_macros.svh
// Assertion helpers used by the checker module net_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and muted while in reset.
`define NET_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and muted while in reset.
`define NET_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/net_pkg.sv
`timescale 1ns / 1ps

package net_pkg;

	localparam int unsigned EPOCH_W = 32;
	localparam int unsigned NODE_W  = 16;

	localparam logic [EPOCH_W-1:0] MIN_EPOCH_RST = 32'd1577836800;
	localparam logic [EPOCH_W-1:0] BACKSTEP_RST  = 32'd86400;

	typedef enum logic [2:0] {
		ST_UPDATED   = 3'd0,
		ST_ADDED     = 3'd1,
		ST_ILLEGAL   = 3'd2,
		ST_BACKSTEP  = 3'd3,
		ST_FULL      = 3'd4,
		ST_FOUND     = 3'd5,
		ST_NOT_FOUND = 3'd6
	} status_t;

	typedef enum logic {
		OP_SET = 1'b0,
		OP_GET = 1'b1
	} op_t;

	typedef enum logic {
		CFG_MIN_EPOCH    = 1'b0,
		CFG_MAX_BACKSTEP = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_DECIDE
	} fsm_t;

	typedef struct packed {
		logic [NODE_W-1:0]  node;
		logic [EPOCH_W-1:0] epoch;
	} entry_t;

endpackage

>>> hw/rtl/net_mem.sv
`timescale 1ns / 1ps

module net_mem
	import net_pkg::*;
#(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned IDX_W = 4
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  entry_t           wr_data,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_data
);

	entry_t mem [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> hw/rtl/node_epoch_table.sv
`timescale 1ns / 1ps

// node_epoch_table: maps a 16-bit node number to a 32-bit epoch in a table of
// TABLE_DEPTH entries held in one synchronous RAM (key and epoch side by side).
// A request is taken only while the engine is idle. It then walks the occupied
// entries from the oldest one up, one RAM read per cycle, and stops at the
// first key match. A decide cycle forms the status, writes the entry back on
// update or append, and loads the output register; the engine stays in the
// decide state while the output register is stalled. A set whose epoch is
// later than time_now or below min_valid_epoch is refused; with the sync
// flag set, a step back of more than max_backstep from the stored epoch is
// refused too.
// A finished result waits in the output register while the next request is
// accepted. RAM contents need no clearing: only entries below the fill count
// are ever read. Configuration writes are taken on every cycle.
module node_epoch_table
	import net_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,  // node_id[15:0], new_epoch[47:16], time_now[79:48]
	input  logic [1:0]  s_axis_tuser,  // op[0], sync[1]
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // epoch_out[31:0]
	output logic [2:0]  m_axis_tuser,  // status[2:0]
	// register write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

	// configuration registers
	logic [EPOCH_W-1:0] min_epoch_q;
	logic [EPOCH_W-1:0] max_back_q;

	// request held for the whole walk
	op_t                op_q;
	logic [NODE_W-1:0]  node_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [EPOCH_W-1:0] now_q;
	logic               sync_q;

	// walk state
	fsm_t               state_q, state_d;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   scan_idx_q;
	logic               chk_v_s1;
	logic [IDX_W-1:0]   chk_slot_s1;
	logic               hit_q;
	logic [IDX_W-1:0]   hit_slot_q;
	logic [EPOCH_W-1:0] hit_epoch_q;

	// output register
	logic               out_valid_q;
	status_t            out_status_q;
	logic [EPOCH_W-1:0] out_epoch_q;

	// RAM ports
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	entry_t             rd_data;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	entry_t             wr_data;

	// decide-cycle signals
	logic               in_xfer;
	logic               out_free;
	logic               key_hit;
	logic               walk_done;
	logic               illegal;
	logic               backstep;
	status_t            status_d;
	logic [EPOCH_W-1:0] epoch_res_d;
	logic               add_d;
	logic [EPOCH_W-1:0] back_diff;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign cfg_ready = 1'b1;

	// Register writes; an index outside the list cannot occur with one index bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_epoch_q <= MIN_EPOCH_RST;
			max_back_q  <= BACKSTEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MIN_EPOCH:    min_epoch_q <= cfg_data;
				CFG_MAX_BACKSTEP: max_back_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Issue one RAM read per cycle while occupied entries remain and no key match is seen.
	assign rd_en   = (state_q == FSM_SCAN) && (scan_idx_q < count_q) && !key_hit;
	assign rd_addr = scan_idx_q[IDX_W-1:0];

	assign key_hit   = (state_q == FSM_SCAN) && chk_v_s1 && (rd_data.node == node_q);
	assign walk_done = (state_q == FSM_SCAN) && !chk_v_s1 && (scan_idx_q >= count_q);

	// Status decision from the held request and the walk result.
	assign illegal   = (epoch_q > now_q) || (epoch_q < min_epoch_q);
	assign back_diff = hit_epoch_q - epoch_q;
	assign backstep  = sync_q && (hit_epoch_q > epoch_q) && (back_diff > max_back_q);

	always_comb begin
		status_d    = ST_NOT_FOUND;
		epoch_res_d = '0;
		add_d       = 1'b0;
		wr_en       = 1'b0;
		wr_addr     = hit_slot_q;
		wr_data.node  = node_q;
		wr_data.epoch = epoch_q;
		if (op_q == OP_GET) begin
			if (hit_q) begin
				status_d    = ST_FOUND;
				epoch_res_d = hit_epoch_q;
			end
		end else if (illegal) begin
			status_d = ST_ILLEGAL;
		end else if (hit_q) begin
			if (backstep) begin
				status_d = ST_BACKSTEP;
			end else begin
				status_d = ST_UPDATED;
				wr_en    = 1'b1;
			end
		end else if (count_q == CNT_FULL) begin
			status_d = ST_FULL;
		end else begin
			status_d = ST_ADDED;
			add_d    = 1'b1;
			wr_en    = 1'b1;
			wr_addr  = count_q[IDX_W-1:0];
		end
		// only commit the write in the cycle that hands off the result
		if (!(state_q == FSM_DECIDE && out_free)) begin
			wr_en = 1'b0;
			add_d = 1'b0;
		end
	end

	// Next state and ready.
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = FSM_SCAN;
				end
			end
			FSM_SCAN: begin
				if (key_hit || walk_done) begin
					state_d = FSM_DECIDE;
				end
			end
			FSM_DECIDE: begin
				if (out_free) begin
					state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Walk control and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			scan_idx_q <= '0;
			chk_v_s1   <= 1'b0;
			hit_q      <= 1'b0;
		end else begin
			if (in_xfer) begin
				scan_idx_q <= '0;
				chk_v_s1   <= 1'b0;
				hit_q      <= 1'b0;
			end else if (state_q == FSM_SCAN) begin
				chk_v_s1 <= rd_en;
				if (rd_en) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
				if (key_hit) begin
					hit_q <= 1'b1;
				end
			end
			if (add_d) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// Payload: held request and the matching entry.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q    <= op_t'(s_axis_tuser[0]);
			sync_q  <= s_axis_tuser[1];
			node_q  <= s_axis_tdata[15:0];
			epoch_q <= s_axis_tdata[47:16];
			now_q   <= s_axis_tdata[79:48];
		end
		if (rd_en) begin
			chk_slot_s1 <= rd_addr;
		end
		if (key_hit) begin
			hit_slot_q  <= chk_slot_s1;
			hit_epoch_q <= rd_data.epoch;
		end
	end

	// Output register: load on decide, drop on transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == FSM_DECIDE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FSM_DECIDE && out_free) begin
			out_status_q <= status_d;
			out_epoch_q  <= epoch_res_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_epoch_q;
	assign m_axis_tuser  = out_status_q;

	net_mem #(
		.DEPTH (TABLE_DEPTH),
		.IDX_W (IDX_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule

>>> hw/rtl/net_chk.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module net_chk
	import net_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [79:0] s_axis_tdata,
	input logic [1:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic        cfg_index,
	input logic [31:0] cfg_data
);

	// a stalled result holds
	`NET_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

	// one request at a time: ready drops after a transfer
	`NET_ASSERT_NXT(a_one_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while busy")

	// the status never takes the unused code
	`NET_ASSERT_NOW(a_status_code, m_axis_tvalid, m_axis_tuser != 3'd7, "unused status code")

	// epoch is zero unless the node was found
	`NET_ASSERT_NOW(a_epoch_zero, m_axis_tvalid && m_axis_tuser != ST_FOUND, m_axis_tdata == 32'd0, "epoch on miss")

endmodule

bind node_epoch_table net_chk u_net_chk (.*);

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import net_pkg::*;

	localparam int TABLE_DEPTH = 16;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 24;

	typedef struct packed {
		op_t         op;
		logic [15:0] node;
		logic [31:0] epoch;
		logic [31:0] now;
		logic        sync;
	} epoch_req_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] epoch;
	} epoch_resp_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	cfg_idx_t    cfg_index;
	logic [31:0] cfg_data;

	// Mirror of the table and its registers, written only by the monitor.
	logic [15:0] key_mem [TABLE_DEPTH];
	logic [31:0] epoch_mem [TABLE_DEPTH];
	int          fill_cnt = 0;
	logic [31:0] cfg_min = MIN_EPOCH_RST;
	logic [31:0] cfg_back = BACKSTEP_RST;

	epoch_req_t  req_q[$];       // requests waiting for the driver
	epoch_resp_t resp_due_q[$];  // responses owed by the block, oldest first
	int          n_queued = 0;
	int          n_taken = 0;
	int          n_fail = 0;
	int          hold_cnt = 0;
	logic        s_taken = 1'b0;
	logic        no_gaps = 1'b0;
	logic        hold_go = 1'b0;

	node_epoch_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Look up the node from the oldest slot upward, apply the request to the
	// mirror and return the response the block owes for it.
	function automatic epoch_resp_t table_apply(epoch_req_t r);
		epoch_resp_t res;
		int slot;
		res.status = ST_NOT_FOUND;
		res.epoch = '0;
		slot = -1;
		for (int i = 0; i < fill_cnt; i++)
			if (slot < 0 && key_mem[i] == r.node)
				slot = i;
		if (r.op == OP_GET) begin
			if (slot >= 0) begin
				res.status = ST_FOUND;
				res.epoch = epoch_mem[slot];
			end
		end else if (r.epoch > r.now || r.epoch < cfg_min) begin
			// refuse future epochs and epochs below the floor before the lookup result is used
			res.status = ST_ILLEGAL;
		end else if (slot >= 0) begin
			if (r.sync && epoch_mem[slot] > r.epoch && epoch_mem[slot] - r.epoch > cfg_back)
				res.status = ST_BACKSTEP;
			else begin
				epoch_mem[slot] = r.epoch;
				res.status = ST_UPDATED;
			end
		end else if (fill_cnt >= TABLE_DEPTH) begin
			res.status = ST_FULL;
		end else begin
			key_mem[fill_cnt] = r.node;
			epoch_mem[fill_cnt] = r.epoch;
			fill_cnt++;
			res.status = ST_ADDED;
		end
		return res;
	endfunction

	// Request driver: advance to the next pending request once the current
	// transfer is done, idling at random unless the gap-free stretch is on.
	always @(negedge clk) begin : drive_req
		epoch_req_t r;
		if (!arst_n)
			s_axis_tvalid <= 1'b0;
		else if (!s_axis_tvalid || s_taken) begin
			if (req_q.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 29)) begin
				r = req_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {r.now, r.epoch, r.node};
				s_axis_tuser <= {r.sync, r.op};
			end else
				s_axis_tvalid <= 1'b0;
		end
	end

	// Result receiver: hold tready low for a long stretch once asked, so the
	// block backs up and stalls its request side; else stall at random unless gap-free.
	always @(negedge clk) begin : drive_resp_ready
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else if (hold_go && hold_cnt < HOLD_CYCLES) begin
			m_axis_tready <= 1'b0;
			hold_cnt++;
		end else
			m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= 29);
	end

	// Monitor: track register writes, predict every accepted request and
	// compare every accepted result with the oldest prediction.
	always @(posedge clk) begin : watch
		epoch_req_t r;
		epoch_resp_t want;
		s_taken <= s_axis_tvalid && s_axis_tready;
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MIN_EPOCH: cfg_min = cfg_data;
				CFG_MAX_BACKSTEP: cfg_back = cfg_data;
				default: ;
			endcase
		end
		if (m_axis_tvalid && m_axis_tready) begin
			if (resp_due_q.size() == 0) begin
				$error("result transfer with no request outstanding: status %0d epoch_out %0h",
					m_axis_tuser, m_axis_tdata);
				n_fail++;
			end else begin
				want = resp_due_q.pop_front();
				if (m_axis_tuser !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
					n_fail++;
				end
				if (m_axis_tdata !== want.epoch) begin
					$error("epoch_out: expected %0h, actual %0h", want.epoch, m_axis_tdata);
					n_fail++;
				end
			end
		end
		if (s_axis_tvalid && s_axis_tready) begin
			r.node = s_axis_tdata[15:0];
			r.epoch = s_axis_tdata[47:16];
			r.now = s_axis_tdata[79:48];
			r.op = op_t'(s_axis_tuser[0]);
			r.sync = s_axis_tuser[1];
			resp_due_q.push_back(table_apply(r));
			n_taken++;
		end
	end

	task automatic queue_req(op_t op, logic [15:0] node, logic [31:0] epoch,
			logic [31:0] now, logic sync);
		epoch_req_t r;
		r.op = op;
		r.node = node;
		r.epoch = epoch;
		r.now = now;
		r.sync = sync;
		req_q.push_back(r);
		n_queued++;
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Wait until every queued request went through and every response came
	// back, then let the engine settle before touching the registers.
	task automatic wait_drained();
		while (n_taken != n_queued || resp_due_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		epoch_req_t r;
		logic [31:0] hint;
		logic [31:0] lo;
		logic [31:0] set_min [6];
		logic [31:0] set_back [6];
		int k;
		int p;
		int sel;

		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_MIN_EPOCH;
		cfg_data = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset settings.
		queue_req(OP_GET, 16'h1234, '0, '0, 1'b0);                      // empty table
		queue_req(OP_SET, 16'h0000, MIN_EPOCH_RST, MIN_EPOCH_RST, 1'b0);  // floor, add
		queue_req(OP_SET, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);  // top, add
		queue_req(OP_GET, 16'hFFFF, '0, '0, 1'b1);
		queue_req(OP_SET, 16'h0000, MIN_EPOCH_RST + 10, MIN_EPOCH_RST + 9, 1'b0); // future
		queue_req(OP_SET, 16'h0000, MIN_EPOCH_RST - 1, 32'hFFFF_FFFF, 1'b0);      // too old
		queue_req(OP_SET, 16'h0000, '0, '0, 1'b1);
		queue_req(OP_SET, 16'h0000, MIN_EPOCH_RST + 100, MIN_EPOCH_RST + 100, 1'b1);
		// backstep one past the limit, exactly at it, then unchecked
		queue_req(OP_SET, 16'hFFFF, 32'hFFFF_FFFF - BACKSTEP_RST - 1, 32'hFFFF_FFFF, 1'b1);
		queue_req(OP_SET, 16'hFFFF, 32'hFFFF_FFFF - BACKSTEP_RST, 32'hFFFF_FFFF, 1'b1);
		queue_req(OP_SET, 16'hFFFF, MIN_EPOCH_RST, 32'hFFFF_FFFF, 1'b0);
		queue_req(OP_GET, 16'h0000, '0, '0, 1'b0);
		// fill the remaining slots, walking a one through the key
		for (k = 0; k < TABLE_DEPTH - 2; k++)
			queue_req(OP_SET, 16'h0001 << k, MIN_EPOCH_RST + k, 32'hFFFF_FFFF, k[0]);
		queue_req(OP_SET, 16'h4000, MIN_EPOCH_RST, MIN_EPOCH_RST, 1'b0);  // full
		queue_req(OP_GET, 16'h8000, '0, '0, 1'b0);                        // miss on full
		queue_req(OP_SET, 16'h2000, MIN_EPOCH_RST, MIN_EPOCH_RST, 1'b1);  // last slot
		wait_drained();

		set_min[0] = MIN_EPOCH_RST;   set_back[0] = BACKSTEP_RST;
		set_min[1] = 32'h0;           set_back[1] = 32'h0;
		set_min[2] = 32'hFFFF_FFFF;   set_back[2] = 32'hFFFF_FFFF;
		set_min[3] = 32'h0;           set_back[3] = 32'hFFFF_FFFF;
		set_min[4] = $urandom_range(32'h7000_0000, 32'h5000_0000);
		set_back[4] = $urandom_range(200000, 0);
		set_min[5] = MIN_EPOCH_RST;   set_back[5] = 32'h1;

		for (p = 0; p < 6; p++) begin
			write_reg(CFG_MIN_EPOCH, set_min[p]);
			write_reg(CFG_MAX_BACKSTEP, set_back[p]);
			@(posedge clk);
			no_gaps = (p == 1);
			if (p == 2)
				hold_go = 1'b1;
			for (k = 0; k < 117; k++) begin
				r.op = ($urandom_range(0, 99) < 30) ? OP_GET : OP_SET;
				r.sync = 1'($urandom_range(0, 1));
				// mostly known keys, so updates and backsteps get exercised
				if (fill_cnt != 0 && $urandom_range(0, 3) != 0) begin
					sel = $urandom_range(0, fill_cnt - 1);
					r.node = key_mem[sel];
					hint = epoch_mem[sel];
				end else begin
					r.node = 16'($urandom);
					hint = $urandom;
				end
				r.epoch = $urandom;
				r.now = $urandom;
				sel = $urandom_range(0, 9);
				case (sel)
					0: ;
					1: begin
						r.epoch = cfg_min - 1;
						r.now = $urandom_range(32'hFFFF_FFFF, r.epoch);
					end
					2: begin
						r.epoch = $urandom_range(32'hFFFF_FFFF, cfg_min);
						r.now = r.epoch - 1;
					end
					3: r.epoch = hint - cfg_back - 1;
					4: r.epoch = hint - cfg_back;
					5: r.epoch = hint + $urandom_range(1000, 0);
					default: r.epoch = $urandom_range(32'hFFFF_FFFF, cfg_min);
				endcase
				if (sel >= 3) begin
					lo = r.epoch + $urandom_range(500, 0);
					r.now = (lo < r.epoch || $urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : lo;
				end
				queue_req(r.op, r.node, r.epoch, r.now, r.sync);
			end
			wait_drained();
		end

		if (n_fail == 0 && resp_due_q.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("testbench NOT OK");
		$finish;
	end

endmodule
